// ===== rtl/bfr_pkg.sv =====
// Shared types, constants and helpers of the 3x3 RGB box filter.
`default_nettype none

package bfr_pkg;

    // Geometry defaults and field widths
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int CH_W          = 8;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 16;
    localparam int IN_ROW_W      = HEIGHT_W + 1;
    localparam int WIDTH_RESET   = 1024;
    localparam int HEIGHT_RESET  = 480;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Operation codes of an input beat
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Nine 8-bit taps sum to at most 2295: 12 bits.
    // s / 9 == (s * 3641) >> 15 exactly for s < 2^15.
    localparam int SUM_W = 12;
    localparam logic [SUM_W-1:0] DIV9_RECIP = 12'd3641;
    localparam int DIV9_SHIFT = 15;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    // Per-item work tag from front to back
    typedef struct packed {
        logic emit;    // item produces an output pixel
        logic last;    // that output closes the frame
        logic top;     // output on first row: drop upper window row
        logic bottom;  // output on last row: drop lower window row
        logic left;    // output on first column: drop left window column
        logic right;   // output on last column: drop right window column
    } t_tag;

    function automatic logic [CH_W-1:0] div_by_9(input logic [SUM_W-1:0] s);
        logic [2*SUM_W-1:0] p;
        p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_RECIP);
        return p[DIV9_SHIFT +: CH_W];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bfr_in_if.sv =====
// Input pixel channel: valid/ready handshake with the pixel payload.
`default_nettype none

interface bfr_in_if import bfr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            operation;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, operation, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfr_out_if.sv =====
// Output pixel channel: valid/ready handshake with the smoothed pixel payload.
`default_nettype none

interface bfr_out_if import bfr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_of_frame;

    modport source (output valid, red_out, green_out, blue_out, last_of_frame, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/box_filter_3x3_rgb_top.sv =====
// Top level: 3x3 RGB box filter, one input beat per cycle unless stalled.
// Path: the input beat that completes a window reaches the output through the
//   queue, line store read, sum and divide stages, one row and one column behind.
// Throughput: one beat per cycle in and out unless the output stalls; the line
//   store RAM, one read and one write port, sets this with one of each per item.
// Reset: counters, queue and handshake cleared; width 1024, height 480. Line store
//   and window contents are masked at frame borders and need no clearing.
`default_nettype none

module box_filter_3x3_rgb_top import bfr_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bfr_in_if.sink                     i_in_beat,
    bfr_out_if.source                  o_out_beat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int TAG_W  = $bits(t_tag);
    localparam int PIX_W  = $bits(t_pix);
    localparam int QW     = CW + TAG_W + PIX_W;

    logic          q_full, q_push, q_pop, q_valid;
    logic [CW-1:0] push_col;
    t_tag          push_tag;
    t_pix          push_pix;
    logic [QW-1:0] q_rdata;
    logic [CW-1:0] pop_col;
    t_tag          pop_tag;
    t_pix          pop_pix;

    bfr_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (i_in_beat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_col      (push_col),
        .o_tag      (push_tag),
        .o_pix      (push_pix)
    );

    bfr_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_col, push_tag, push_pix}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign pop_col = q_rdata[QW-1:TAG_W+PIX_W];
    assign pop_tag = q_rdata[TAG_W+PIX_W-1:PIX_W];
    assign pop_pix = q_rdata[PIX_W-1:0];

    bfr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_col    (pop_col),
        .i_q_tag    (pop_tag),
        .i_q_pix    (pop_pix),
        .o_pop      (q_pop),
        .o_out_beat (o_out_beat)
    );

endmodule

`default_nettype wire

// ===== rtl/bfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old word on an address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bfr_queue.sv =====
// Short register FIFO that decouples the front from the back.
`default_nettype none

module bfr_queue #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 4,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic      [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill-level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfr_front.sv =====
// Front end: takes input beats, tracks stream and output positions, classifies items.
`default_nettype none

module bfr_front import bfr_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bfr_in_if.sink                     i_in_beat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output logic      [CW-1:0]         o_col,
    output t_tag                       o_tag,
    output t_pix                       o_pix
);

    // Last column index of the frame, width clamped to [2, MAX_WIDTH]
    function automatic logic [CW-1:0] clamp_last_col(input logic [WIDTH_W-1:0] v);
        logic [CW-1:0] lc;
        if (v < WIDTH_W'(2)) begin
            lc = CW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            lc = CW'(MAX_WIDTH - 1);
        end else begin
            lc = CW'(v - WIDTH_W'(1));
        end
        return lc;
    endfunction

    // Last row index of the frame, height clamped to at least 2
    function automatic logic [HEIGHT_W-1:0] clamp_last_row(input logic [HEIGHT_W-1:0] v);
        logic [HEIGHT_W-1:0] lr;
        if (v < HEIGHT_W'(2)) begin
            lr = HEIGHT_W'(1);
        end else begin
            lr = v - HEIGHT_W'(1);
        end
        return lr;
    endfunction

    logic [CW-1:0]       r_last_col, n_last_col;
    logic [HEIGHT_W-1:0] r_last_row, n_last_row;
    logic [CW-1:0]       r_in_col, n_in_col;
    logic [IN_ROW_W-1:0] r_in_row, n_in_row;
    logic [CW-1:0]       r_out_col, n_out_col;
    logic [HEIGHT_W-1:0] r_out_row, n_out_row;

    logic accept, is_drain, in_done, work, emit, last, cfg_hit;

    assign i_in_beat.ready = !i_q_full;
    assign accept   = i_in_beat.valid && !i_q_full;
    assign is_drain = (i_in_beat.operation == OP_DRAIN);
    assign in_done  = (r_in_row > {1'b0, r_last_row});

    // Early drains and excess pixels are taken but dropped
    assign work = accept && (is_drain == in_done);
    assign emit = (r_in_row >= IN_ROW_W'(2))
               || ((r_in_row == IN_ROW_W'(1)) && (r_in_col != '0));
    assign last = (r_out_row == r_last_row) && (r_out_col == r_last_col);

    // Work item to the back
    assign o_push       = work;
    assign o_col        = r_in_col;
    assign o_tag.emit   = emit;
    assign o_tag.last   = emit && last;
    assign o_tag.top    = (r_out_row == '0);
    assign o_tag.bottom = (r_out_row == r_last_row);
    assign o_tag.left   = (r_out_col == '0);
    assign o_tag.right  = (r_out_col == r_last_col);
    assign o_pix        = is_drain ? '0
                        : {i_in_beat.red_in, i_in_beat.green_in, i_in_beat.blue_in};

    assign cfg_hit = i_cfg_we
                  && ((i_cfg_idx == CFG_IMAGE_WIDTH) || (i_cfg_idx == CFG_IMAGE_HEIGHT));

    // Position counters and register writes
    always_comb begin
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        if (cfg_hit) begin
            if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                n_last_col = clamp_last_col(i_cfg_data[WIDTH_W-1:0]);
            end else begin
                n_last_row = clamp_last_row(i_cfg_data[HEIGHT_W-1:0]);
            end
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (work) begin
            if (r_in_col == r_last_col) begin
                n_in_col = '0;
                n_in_row = r_in_row + IN_ROW_W'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (last) begin
                    // Frame complete: everything restarts at the origin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (r_out_col == r_last_col) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + HEIGHT_W'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= clamp_last_col(WIDTH_W'(WIDTH_RESET));
            r_last_row <= clamp_last_row(HEIGHT_W'(HEIGHT_RESET));
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfr_back.sv =====
// Back end: line stores, 3x3 window, masked sum, divide by nine, output register.
`default_nettype none

module bfr_back import bfr_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire logic [CW-1:0] i_q_col,
    input  wire t_tag          i_q_tag,
    input  wire t_pix          i_q_pix,
    output logic               o_pop,
    bfr_out_if.source          o_out_beat
);

    localparam int PIX_W = $bits(t_pix);

    logic adv;

    // Stage 1: line store word read, item held
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    t_tag          r_s1_tag;
    t_pix          r_s1_pix;
    logic [2*PIX_W-1:0] ram_rdata;
    t_pix          upper_rd, lower_rd;

    // Window columns: r_c1 = left, r_c2 = middle before this item's shift
    t_pix r_c1 [3];
    t_pix r_c2 [3];
    t_pix col_new [3];
    t_pix taps [3][3];
    logic row_on [3];
    logic col_on [3];

    logic [SUM_W-1:0] sum_r, sum_g, sum_b;

    // Stage 2: channel sums
    logic             r_s2_valid;
    logic             r_s2_last;
    logic [SUM_W-1:0] r_s2_sum_r, r_s2_sum_g, r_s2_sum_b;

    // Output register
    logic            r_out_valid;
    logic [CH_W-1:0] r_out_red, r_out_green, r_out_blue;
    logic            r_out_last;

    // Whole back pipeline moves unless the output beat is stuck
    assign adv   = !r_out_valid || o_out_beat.ready;
    assign o_pop = adv && i_q_valid;

    // Word layout: upper line in the high half, lower line in the low half
    bfr_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata ({lower_rd, r_s1_pix}),
        .i_re    (o_pop),
        .i_raddr (i_q_col),
        .o_rdata (ram_rdata)
    );

    assign upper_rd = ram_rdata[2*PIX_W-1:PIX_W];
    assign lower_rd = ram_rdata[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_col <= i_q_col;
            r_s1_tag <= i_q_tag;
            r_s1_pix <= i_q_pix;
        end
    end

    // Incoming window column, top to bottom
    assign col_new[0] = upper_rd;
    assign col_new[1] = lower_rd;
    assign col_new[2] = r_s1_pix;

    // Window shift
    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_c1[r] <= r_c2[r];
                r_c2[r] <= col_new[r];
            end
        end
    end

    // Border masks: rows and columns outside the image count as zero
    assign row_on[0] = !r_s1_tag.top;
    assign row_on[1] = 1'b1;
    assign row_on[2] = !r_s1_tag.bottom;
    assign col_on[0] = !r_s1_tag.left;
    assign col_on[1] = 1'b1;
    assign col_on[2] = !r_s1_tag.right;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            taps[r][0] = r_c1[r];
            taps[r][1] = r_c2[r];
            taps[r][2] = col_new[r];
        end
    end

    // Masked 3x3 sum per channel
    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if (row_on[r] && col_on[k]) begin
                    sum_r = sum_r + SUM_W'(taps[r][k].red);
                    sum_g = sum_g + SUM_W'(taps[r][k].green);
                    sum_b = sum_b + SUM_W'(taps[r][k].blue);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_tag.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_last  <= r_s1_tag.last;
            r_s2_sum_r <= sum_r;
            r_s2_sum_g <= sum_g;
            r_s2_sum_b <= sum_b;
        end
    end

    // Divide by nine into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_red   <= div_by_9(r_s2_sum_r);
            r_out_green <= div_by_9(r_s2_sum_g);
            r_out_blue  <= div_by_9(r_s2_sum_b);
            r_out_last  <= r_s2_last;
        end
    end

    assign o_out_beat.valid         = r_out_valid;
    assign o_out_beat.red_out       = r_out_red;
    assign o_out_beat.green_out     = r_out_green;
    assign o_out_beat.blue_out      = r_out_blue;
    assign o_out_beat.last_of_frame = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/bfr_checker.sv =====
// Port-level checks of the box filter top, bound to it.
`default_nettype none

module bfr_checker import bfr_pkg::*; (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire logic [CH_W-1:0] i_out_red,
    input wire logic [CH_W-1:0] i_out_green,
    input wire logic [CH_W-1:0] i_out_blue,
    input wire logic            i_out_last
);

    // Reset empties the output register
    a_rst_out_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output beat valid right after reset");

    // Reset empties the queue, so input is taken right away
    a_rst_in_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

    // A stalled output beat stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> $stable({i_out_red, i_out_green, i_out_blue, i_out_last}))
        else $error("output payload changed while stalled");

endmodule

bind box_filter_3x3_rgb_top bfr_checker u_bfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in_beat.ready),
    .i_out_valid (o_out_beat.valid),
    .i_out_ready (o_out_beat.ready),
    .i_out_red   (o_out_beat.red_out),
    .i_out_green (o_out_beat.green_out),
    .i_out_blue  (o_out_beat.blue_out),
    .i_out_last  (o_out_beat.last_of_frame)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the 3x3 RGB box filter: raster frames checked against a predictor.
module tb_top;
    import bfr_pkg::*;

    localparam int CLK_LIMIT    = 1_000_000;
    localparam int QUIET_CYCLES = 12;       // covers the pipe after the last beat
    localparam int PHASE_BEATS  = 100;
    localparam int WIDE_BEATS   = 1040;     // runs past one clamped 1024-pixel row
    localparam int NEIGHBORHOOD = 9;
    localparam int MIN_SIDE     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic op;
        t_pix pix;
    } pix_beat_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } smoothed_t;

    // Clock, reset, config port
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bfr_in_if  pix_in_bus ();
    bfr_out_if pix_out_bus ();

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    box_filter_3x3_rgb_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (pix_in_bus),
        .o_out_beat (pix_out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor state: geometry, line stores, window, stream positions
    logic [WIDTH_W-1:0]  width_reg  = WIDTH_W'(WIDTH_RESET);
    logic [HEIGHT_W-1:0] height_reg = HEIGHT_W'(HEIGHT_RESET);
    t_pix        upper_row_store [DEF_MAX_WIDTH] = '{default: '0};
    t_pix        lower_row_store [DEF_MAX_WIDTH] = '{default: '0};
    t_pix        window3x3 [3][3] = '{default: '0};
    int unsigned in_col, in_row, out_col, out_row;

    // Traffic bookkeeping
    pix_beat_t   pixel_backlog [$];
    smoothed_t   pending_smoothed [$];
    pix_beat_t   beat_on_bus;
    smoothed_t   want;
    bit          beat_in_flight = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          beats_queued   = 0;
    int          beats_taken    = 0;
    int          beats_ignored  = 0;
    int          pixels_checked = 0;
    int          frames_closed  = 0;
    int          mismatches     = 0;
    int          cycle_count    = 0;

    function automatic int unsigned eff_width();
        if (width_reg < MIN_SIDE) return MIN_SIDE;
        if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < MIN_SIDE) ? MIN_SIDE : height_reg;
    endfunction

    function automatic void clear_position();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // One accepted beat through the filter; pushes the smoothed pixel it completes
    function automatic void smooth_pixel_step(input pix_beat_t b);
        int unsigned w, h, col;
        int          sum_r, sum_g, sum_b, r, k;
        logic        emit, last;
        t_pix        px, tap;
        smoothed_t   res;
        w = eff_width();
        h = eff_height();
        // early drain or excess pixel: dropped
        if ((b.op == OP_DRAIN) != (in_row >= h)) begin
            beats_ignored++;
            return;
        end
        px  = (b.op == OP_DRAIN) ? t_pix'('0) : b.pix;
        col = in_col % DEF_MAX_WIDTH;
        for (r = 0; r < 3; r++) begin
            window3x3[r][0] = window3x3[r][1];
            window3x3[r][1] = window3x3[r][2];
        end
        window3x3[0][2]      = upper_row_store[col];
        window3x3[1][2]      = lower_row_store[col];
        window3x3[2][2]      = px;
        upper_row_store[col] = lower_row_store[col];
        lower_row_store[col] = px;

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (!emit) return;

        // taps outside the image count as zero
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (r = 0; r < 3; r++) begin
            if (r == 0 && out_row == 0) continue;
            if (r == 2 && out_row >= h - 1) continue;
            for (k = 0; k < 3; k++) begin
                if (k == 0 && out_col == 0) continue;
                if (k == 2 && out_col >= w - 1) continue;
                tap = window3x3[r][k];
                sum_r += tap.red;
                sum_g += tap.green;
                sum_b += tap.blue;
            end
        end
        last      = (out_row >= h - 1) && (out_col >= w - 1);
        res.red   = CH_W'(sum_r / NEIGHBORHOOD);
        res.green = CH_W'(sum_g / NEIGHBORHOOD);
        res.blue  = CH_W'(sum_b / NEIGHBORHOOD);
        res.last  = last;
        pending_smoothed.push_back(res);

        if (last) begin
            clear_position();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on output beat %0d: %s", $time, pixels_checked, what);
        mismatches++;
    endtask

    // Input driver: pops the backlog, holds the beat until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in_bus.valid <= 1'b0;
        end else begin
            if (pix_in_bus.valid && pix_in_bus.ready) begin
                smooth_pixel_step(beat_on_bus);
                beats_taken++;
                beat_in_flight = 1'b0;
            end
            if (!pix_in_bus.valid || pix_in_bus.ready) begin
                if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    beat_on_bus              = pixel_backlog.pop_front();
                    beat_in_flight           = 1'b1;
                    pix_in_bus.valid        <= 1'b1;
                    pix_in_bus.operation    <= beat_on_bus.op;
                    pix_in_bus.red_in       <= beat_on_bus.pix.red;
                    pix_in_bus.green_in     <= beat_on_bus.pix.green;
                    pix_in_bus.blue_in      <= beat_on_bus.pix.blue;
                end else begin
                    pix_in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random backpressure, field-by-field compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out_bus.ready <= 1'b0;
        end else begin
            if (pix_out_bus.valid && pix_out_bus.ready) begin
                if (pending_smoothed.size() == 0) begin
                    report_mismatch("output beat with nothing expected");
                end else begin
                    want = pending_smoothed.pop_front();
                    if (pix_out_bus.red_out !== want.red)
                        report_mismatch($sformatf("red %0h, expected %0h",
                                                  pix_out_bus.red_out, want.red));
                    if (pix_out_bus.green_out !== want.green)
                        report_mismatch($sformatf("green %0h, expected %0h",
                                                  pix_out_bus.green_out, want.green));
                    if (pix_out_bus.blue_out !== want.blue)
                        report_mismatch($sformatf("blue %0h, expected %0h",
                                                  pix_out_bus.blue_out, want.blue));
                    if (pix_out_bus.last_of_frame !== want.last)
                        report_mismatch($sformatf("last_of_frame %b, expected %b",
                                                  pix_out_bus.last_of_frame, want.last));
                end
                pixels_checked++;
                if (pix_out_bus.last_of_frame === 1'b1) frames_closed++;
            end
            pix_out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CLK_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_smoothed.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Wait for backlog, bus and expectations to empty, then settle
    task automatic wait_quiet(input int settle);
        while (pixel_backlog.size() != 0 || beat_in_flight || pending_smoothed.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_IMAGE_WIDTH: begin
                width_reg = data[WIDTH_W-1:0];
                clear_position();
            end
            CFG_IMAGE_HEIGHT: begin
                height_reg = data[HEIGHT_W-1:0];
                clear_position();
            end
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void queue_beat(input logic op, input t_pix pix, input bit counts);
        pix_beat_t b;
        b.op  = op;
        b.pix = pix;
        pixel_backlog.push_back(b);
        if (counts) beats_queued++;
    endfunction

    // Random pixel, skewed toward saturated and dark channels
    function automatic t_pix rand_pix(input bit bright);
        t_pix p;
        p = t_pix'($urandom);
        if (bright && $urandom_range(7) != 0) return t_pix'('1);
        case ($urandom_range(7))
            0: p = '1;
            1: p = '0;
            2: p.green = '1;
            default: ;
        endcase
        return p;
    endfunction

    // One frame at the current geometry; n_pix 0 means the whole frame plus drains
    task automatic run_frame(input int unsigned n_pix, input bit noisy, input bit hold);
        int unsigned w, h, total, hold_at, i;
        bit          bright;
        w       = eff_width();
        h       = eff_height();
        total   = w * h;
        if (n_pix == 0) n_pix = total;
        bright  = ($urandom_range(5) == 0);
        hold_at = hold ? $urandom_range(n_pix - 1) : n_pix;
        for (i = 0; i < n_pix; i++) begin
            if (i == hold_at) wait_quiet(0);
            if (noisy && $urandom_range(11) == 0) queue_beat(OP_DRAIN, rand_pix(1'b0), 1'b0);
            queue_beat(OP_PIXEL, rand_pix(bright), 1'b1);
        end
        if (n_pix == total) begin
            for (i = 0; i <= w; i++) begin
                if (noisy && $urandom_range(7) == 0) queue_beat(OP_PIXEL, rand_pix(1'b0), 1'b0);
                queue_beat(OP_DRAIN, rand_pix(1'b0), 1'b1);
            end
        end
    endtask

    // New small geometry, now and then a clamped one; junk above the width field
    task automatic random_geometry();
        logic [CFG_DATA_W-1:0] wd, ht;
        wait_quiet(QUIET_CYCLES);
        case ($urandom_range(9))
            0:       wd = CFG_DATA_W'($urandom_range(1));
            1, 2:    wd = CFG_DATA_W'($urandom_range(64, 17));
            default: wd = CFG_DATA_W'($urandom_range(16, 2));
        endcase
        wd[CFG_DATA_W-1:WIDTH_W] = $urandom;
        ht = ($urandom_range(4) == 0) ? CFG_DATA_W'($urandom_range(10, 6))
                                      : CFG_DATA_W'($urandom_range(5));
        if ($urandom_range(3) != 0) write_reg(CFG_IMAGE_WIDTH, wd);
        write_reg(CFG_IMAGE_HEIGHT, ht);
    endtask

    // Stimulus
    initial begin
        int ph, pick, phase_start, i;
        pix_in_bus.valid     = 1'b0;
        pix_in_bus.operation = OP_PIXEL;
        pix_in_bus.red_in    = '0;
        pix_in_bus.green_in  = '0;
        pix_in_bus.blue_in   = '0;
        pix_out_bus.ready    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clamped 2x2 with an early drain and an excess pixel
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(1));
        queue_beat(OP_DRAIN, t_pix'('1), 1'b1);
        queue_beat(OP_PIXEL, t_pix'('1), 1'b1);
        queue_beat(OP_PIXEL, t_pix'('1), 1'b1);
        queue_beat(OP_PIXEL, t_pix'('0), 1'b1);
        queue_beat(OP_PIXEL, t_pix'{8'hFF, 8'h00, 8'hA5}, 1'b1);
        queue_beat(OP_PIXEL, t_pix'(24'h5A3C96), 1'b1);
        for (i = 0; i < 3; i++) queue_beat(OP_DRAIN, t_pix'('0), 1'b1);
        wait_quiet(QUIET_CYCLES);

        // Directed: near-saturated 3x3, a spare-index write mid-frame leaves the frame alone
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        for (i = 0; i < 5; i++) queue_beat(OP_PIXEL, t_pix'('1), 1'b1);
        wait_quiet(QUIET_CYCLES);
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        for (i = 0; i < 3; i++) queue_beat(OP_PIXEL, t_pix'('1), 1'b1);
        queue_beat(OP_PIXEL, t_pix'(24'h80017F), 1'b1);
        for (i = 0; i < 4; i++) queue_beat(OP_DRAIN, t_pix'('1), 1'b1);

        // Random phases: slow receiver, slow sender, then full rate
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 14; recv_idle_pct = 84; end
                1: begin send_idle_pct = 84; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_geometry();
            phase_start = beats_queued;
            run_frame(0, 1'b1, 1'b1);

            if (ph == 0) begin
                // tallest frame, abandoned after a few rows
                wait_quiet(QUIET_CYCLES);
                write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(4));
                write_reg(CFG_IMAGE_HEIGHT, '1);
                run_frame(22, 1'b1, 1'b0);
                wait_quiet(QUIET_CYCLES);
                write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
                run_frame(10, 1'b0, 1'b0);
                random_geometry();
            end

            while (beats_queued - phase_start < PHASE_BEATS) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    random_geometry();
                end else if (pick < 15) begin
                    run_frame($urandom_range(eff_width() * eff_height() - 1, 1), 1'b1, 1'b0);
                    random_geometry();
                end else begin
                    run_frame(0, ($urandom_range(2) == 0), 1'b0);
                end
            end
        end

        // Widest frame, width register past the maximum; first row and a bit of the second
        wait_quiet(QUIET_CYCLES);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(2047));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        run_frame(WIDE_BEATS, 1'b1, 1'b0);

        wait_quiet(QUIET_CYCLES);
        $display("Covered %0d accepted beats (%0d dropped as early drain or excess pixel),",
                 beats_taken, beats_ignored);
        $display("%0d smoothed pixels over %0d closed frames, widths 2..1024, heights 2..65535.",
                 pixels_checked, frames_closed);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== box_filter_3x3_rgb_top.f =====
rtl/bfr_pkg.sv
rtl/bfr_in_if.sv
rtl/bfr_out_if.sv
rtl/bfr_ram.sv
rtl/bfr_queue.sv
rtl/bfr_front.sv
rtl/bfr_back.sv
rtl/box_filter_3x3_rgb_top.sv
rtl/bfr_checker.sv
tb/tb_top.sv
